// ===== rtl/core/matrix_vector_accumulate_core_defines.svh =====
// Assertion macros for the matrix-vector accumulate core
`ifndef MATRIX_VECTOR_ACCUMULATE_CORE_DEFINES_SVH
`define MATRIX_VECTOR_ACCUMULATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define MVA_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mva: same-cycle check failed");

`define MVA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mva: next-cycle check failed");

`else

`define MVA_ASSERT_SAME(label, clk, rst_n, cond, prop)

`define MVA_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/core/mva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mva_pkg;

    localparam int COL_W      = 10;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 48;
    localparam int COLS_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_COLS   = 1024;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_MATRIX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

    typedef struct packed {
        logic                     action;
        logic [COL_W-1:0]         column;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] row_start_value;
    } item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] row_result;
        logic                    saturated;
    } result_t;

    typedef struct packed {
        logic capture;
        logic index;
        logic write;
        logic read;
        logic mul;
        logic acc;
    } dp_cmd_t;

    typedef struct packed {
        logic action;
        logic emit;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mva_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mva_item_if;
    logic              valid;
    logic              ready;
    mva_pkg::item_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mva_result_if;
    logic              valid;
    logic              ready;
    mva_pkg::result_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mva_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mva_datapath #(
    parameter int VEC_LEN = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [mva_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mva_pkg::DATA_W-1:0]          cfg_data,
    input  wire mva_pkg::item_t                      item,
    input  wire mva_pkg::dp_cmd_t                    cmd,
    output mva_pkg::dp_status_t                      status,
    output mva_pkg::result_t                         result
);

    localparam int AW      = $clog2(VEC_LEN);
    localparam int LIM_MAX = (VEC_LEN < mva_pkg::MAX_COLS) ? VEC_LEN : mva_pkg::MAX_COLS;
    localparam logic [mva_pkg::COLS_W-1:0] LIM_MAX_V = mva_pkg::COLS_W'(LIM_MAX);
    localparam logic signed [mva_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(mva_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [mva_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(mva_pkg::ACC_W-1){1'b0}}};
    localparam logic signed [mva_pkg::DATA_W-1:0] T_MAX = {1'b0, {(mva_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [mva_pkg::DATA_W-1:0] T_MIN = {1'b1, {(mva_pkg::DATA_W-1){1'b0}}};

    // configuration
    logic signed [mva_pkg::DATA_W-1:0] alpha_reg;
    logic signed [mva_pkg::DATA_W-1:0] beta_reg;
    logic [mva_pkg::COLS_W-1:0]        cols_reg;

    // request capture and pipeline
    logic                              action_reg;
    logic [mva_pkg::COL_W-1:0]         column_reg;
    logic signed [mva_pkg::DATA_W-1:0] value_reg;
    logic signed [mva_pkg::DATA_W-1:0] start_reg;
    logic [AW-1:0]                     idx_reg;
    logic signed [63:0]                prod1_reg;
    logic signed [mva_pkg::DATA_W-1:0] t_reg;
    logic                              tclip_reg;
    logic signed [mva_pkg::DATA_W-1:0] x_reg;
    logic signed [63:0]                prod2_reg;

    // row state
    logic signed [mva_pkg::ACC_W-1:0]  acc_reg;
    logic                              clip_reg;
    logic signed [mva_pkg::ACC_W-1:0]  acc_next;
    logic                              clip_next;

    // output register
    logic signed [mva_pkg::ACC_W-1:0]  row_result_reg;
    logic                              sat_reg;

    logic signed [mva_pkg::DATA_W-1:0] vec_mem [VEC_LEN];

    logic [AW-1:0]                     idx_calc;
    logic signed [47:0]                t_shift;
    logic signed [mva_pkg::DATA_W-1:0] t_sat;
    logic                              t_clip;
    logic signed [mva_pkg::ACC_W-1:0]  p_val;
    logic signed [mva_pkg::ACC_W-1:0]  acc_base;
    logic signed [49:0]                sum;
    logic                              sum_clip;
    logic [mva_pkg::COLS_W-1:0]        limit;
    logic [mva_pkg::COL_W-1:0]         last_col;

    // column modulo store depth
    generate
        if (VEC_LEN >= mva_pkg::MAX_COLS) begin : g_idx_direct
            assign idx_calc = AW'(column_reg);
        end
        else begin : g_idx_mod
            // reciprocal multiply, exact for every 10-bit column
            localparam int RECIP_SH = 20;
            localparam int PROD_W   = mva_pkg::COL_W + RECIP_SH;
            localparam logic [RECIP_SH-1:0] RECIP =
                RECIP_SH'(((1 << RECIP_SH) + VEC_LEN - 1) / VEC_LEN);
            logic [PROD_W-1:0]          recip_prod;
            logic [mva_pkg::COL_W-1:0]  quot;
            logic [mva_pkg::COL_W-1:0]  rem;
            always_comb
            begin
                recip_prod = PROD_W'(column_reg) * PROD_W'(RECIP);
                quot       = recip_prod[PROD_W-1:RECIP_SH];
                rem        = column_reg - mva_pkg::COL_W'(quot * mva_pkg::COL_W'(VEC_LEN));
                idx_calc   = AW'(rem);
            end
        end
    endgenerate

    always_comb
    begin
        t_shift = prod1_reg[63:16];
        t_clip  = !((&t_shift[47:31]) || !(|t_shift[47:31]));
        if (t_clip)
        begin
            t_sat = t_shift[47] ? T_MIN : T_MAX;
        end
        else
        begin
            t_sat = t_shift[mva_pkg::DATA_W-1:0];
        end
    end

    always_comb
    begin
        p_val    = prod2_reg[63:16];
        acc_base = (column_reg == '0) ? mva_pkg::ACC_W'(start_reg) : acc_reg;
        sum      = 50'(acc_base) - 50'(beta_reg) + 50'(p_val);
        sum_clip = !((&sum[49:47]) || !(|sum[49:47]));
        if (sum_clip)
        begin
            acc_next = sum[49] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = sum[mva_pkg::ACC_W-1:0];
        end
        clip_next = ((column_reg == '0) ? 1'b0 : clip_reg) | tclip_reg | sum_clip;
    end

    always_comb
    begin
        if (cols_reg == '0)
        begin
            limit = mva_pkg::COLS_W'(1);
        end
        else if (cols_reg > LIM_MAX_V)
        begin
            limit = LIM_MAX_V;
        end
        else
        begin
            limit = cols_reg;
        end
        last_col = mva_pkg::COL_W'(limit - mva_pkg::COLS_W'(1));
    end

    assign status.action = action_reg;
    assign status.emit   = (column_reg == last_col);

    assign result.row_result = row_result_reg;
    assign result.saturated  = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            beta_reg  <= '0;
            cols_reg  <= mva_pkg::COLS_W'(mva_pkg::MAX_COLS);
            acc_reg   <= '0;
            clip_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mva_pkg::REG_ALPHA: alpha_reg <= cfg_data;
                    mva_pkg::REG_BETA:  beta_reg  <= cfg_data;
                    mva_pkg::REG_COLS:  cols_reg  <= cfg_data[mva_pkg::COLS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.acc)
            begin
                acc_reg  <= acc_next;
                clip_reg <= clip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= item.action;
            column_reg <= item.column;
            value_reg  <= item.value;
            start_reg  <= item.row_start_value;
        end
        if (cmd.index)
        begin
            idx_reg   <= idx_calc;
            prod1_reg <= 64'(value_reg) * 64'(alpha_reg);
        end
        if (cmd.read)
        begin
            x_reg     <= vec_mem[idx_reg];
            t_reg     <= t_sat;
            tclip_reg <= t_clip;
        end
        if (cmd.write)
        begin
            vec_mem[idx_reg] <= value_reg;
        end
        if (cmd.mul)
        begin
            prod2_reg <= 64'(t_reg) * 64'(x_reg);
        end
        if (cmd.acc && status.emit)
        begin
            row_result_reg <= acc_next;
            sat_reg        <= clip_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mva_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_vector_accumulate_core_defines.svh"

module mva_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire mva_pkg::dp_status_t  status,
    output mva_pkg::dp_cmd_t          cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INDEX = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_blocked;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_blocked = status.emit && out_valid_reg && !out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_INDEX;
                end
            end
            S_INDEX:
            begin
                cmd.index  = 1'b1;
                state_next = (status.action == mva_pkg::ACT_LOAD) ? S_WRITE : S_READ;
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!out_blocked)
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_IDLE;
                    if (status.emit)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MVA_ASSERT_NEXT(a_accept_to_index, clk, rst_n, in_valid && in_ready, state_reg == S_INDEX)
    `MVA_ASSERT_NEXT(a_stall_holds_acc, clk, rst_n, (state_reg == S_ACC) && out_blocked, state_reg == S_ACC)
    `MVA_ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, cmd.acc && status.emit, out_valid_reg)
    `MVA_ASSERT_SAME(a_acc_not_blocked, clk, rst_n, cmd.acc, !out_blocked)

endmodule

`default_nettype wire

// ===== rtl/core/matrix_vector_accumulate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role   Payload                                   Handshake
// items     sink   action, column, value, row_start_value    valid/ready
// results   source row_result, saturated                     valid/ready
// cfg       write  cfg_we, cfg_index, cfg_data               cfg_we only
//
// A load request runs capture, index and store write; a matrix request runs
// capture, index and alpha product, store read, second product, accumulate,
// serialised by the two-multiplier chain and single store port. Reset sets
// cols to MAX_COLS, clears alpha, beta, accumulator, clip flag and control,
// not the vector store. A finished row waits in the output register;
// a further request is taken meanwhile and stalls only in its accumulate
// cycle if it would finish a row while the previous one is still held.

module matrix_vector_accumulate_core #(
    parameter int VEC_LEN = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mva_item_if.sink                             items,
    mva_result_if.source                         results,
    input  wire logic                            cfg_we,
    input  wire logic [mva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mva_pkg::DATA_W-1:0]      cfg_data
);

    mva_pkg::dp_cmd_t    cmd;
    mva_pkg::dp_status_t status;
    mva_pkg::result_t    result;
    logic                in_ready;
    logic                out_valid;

    assign items.ready     = in_ready;
    assign results.valid   = out_valid;
    assign results.payload = result;

    mva_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mva_datapath #(
        .VEC_LEN (VEC_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (items.payload),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire
